// ===== hdl/rakt_pkg.sv =====
// ----------------------------------------------------------------------------
// rakt_pkg
// Shared constants and types for the reference-count aging key table.
// ----------------------------------------------------------------------------
package rakt_pkg;

  localparam int CAPACITY = 64;
  localparam int REF_BITS = 16;

  localparam int KEY_W    = 32;
  localparam int LWM_W    = 7;
  localparam int STAT_W   = 3;
  localparam int PORT_REF_W = 16;
  localparam int PORT_CNT_W = 7;

  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int GROUP    = 8;
  localparam int GCNT_W   = $clog2(GROUP + 1);
  localparam int NGROUPS  = (CAPACITY + GROUP - 1) / GROUP;
  localparam int GRP_W    = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int EVEC_W   = NGROUPS * GROUP;

  localparam logic [REF_BITS-1:0] REF_MAX   = '1;
  localparam logic [LWM_W-1:0]    LWM_RESET = LWM_W'(32);

  typedef enum logic [STAT_W-1:0] {
    ST_HIT      = 3'd0,
    ST_INSERTED = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_CLEANED  = 3'd3,
    ST_SKIPPED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_COUNT
  } state_t;

  typedef enum logic {
    CMD_REF   = 1'b0,
    CMD_CLEAN = 1'b1
  } cmd_t;

  typedef struct packed {
    logic             exec_ref;
    logic             exec_clean;
    logic             insert_ok;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

  typedef struct packed {
    logic                free_seen;
    logic                hit_any;
    logic [REF_BITS-1:0] hit_refs;
  } chain_t;

endpackage

// ===== hdl/rakt_cell.sv =====
// ----------------------------------------------------------------------------
// rakt_cell
// One table entry: valid bit, key and count, with its link in the cell chain
// (first-free pick, hit flag and hit count ripple to the next cell).
// ----------------------------------------------------------------------------
module rakt_cell (
  input  logic                clk,
  input  logic                rst,
  input  rakt_pkg::cell_ctl_t ctl,
  input  rakt_pkg::chain_t    chain_in,
  output rakt_pkg::chain_t    chain_out,
  output logic                valid,
  output logic                evict
);

  logic [rakt_pkg::KEY_W-1:0]    key;
  logic [rakt_pkg::REF_BITS-1:0] refs;
  logic [rakt_pkg::REF_BITS-1:0] refs_inc;
  logic [rakt_pkg::REF_BITS-1:0] refs_dec;
  logic                          match;
  logic                          first_free;
  logic                          take;

  assign match      = valid && (key == ctl.key);
  assign refs_inc   = (refs == rakt_pkg::REF_MAX) ? refs : refs + 1'b1;
  assign refs_dec   = (refs == '0) ? refs : refs - 1'b1;
  assign first_free = !valid && !chain_in.free_seen;
  assign take       = ctl.exec_ref && ctl.insert_ok && first_free;
  assign evict      = valid && (refs_dec == '0);

  assign chain_out.free_seen = chain_in.free_seen | !valid;
  assign chain_out.hit_any   = chain_in.hit_any | match;
  assign chain_out.hit_refs  = chain_in.hit_refs | (match ? refs_inc : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (ctl.exec_clean && evict) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key  <= ctl.key;
      refs <= rakt_pkg::REF_BITS'(1);
    end else if (ctl.exec_ref && match) begin
      refs <= refs_inc;
    end else if (ctl.exec_clean && valid) begin
      refs <= refs_dec;
    end
  end

endmodule

// ===== hdl/refcount_aging_key_table_top.sv =====
// ----------------------------------------------------------------------------
// refcount_aging_key_table_top
// Key table with per-entry reference counts, insert on miss, and aging clean.
// ----------------------------------------------------------------------------
// Reference: a taken start moves to S_EXEC, which makes one compare/update
//   pass of the cell row and registers done; busy holds off a new start till then.
// Clean: S_EXEC ages the counts, then S_COUNT sums the eviction flags,
//   8 cells per cycle, and done follows the last group. Skipped: S_EXEC only.
// Reset: valid bits and entry count clear, clean floor = 32.
// Results cannot be stalled; each is on the ports for one cycle with done.
// ----------------------------------------------------------------------------
module refcount_aging_key_table_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               command,
  input  logic signed [rakt_pkg::KEY_W-1:0]  key,
  input  logic                               gate_clean,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rakt_pkg::LWM_W-1:0]         cfg_data,
  output logic                               done,
  output logic [rakt_pkg::STAT_W-1:0]        status,
  output logic [rakt_pkg::PORT_REF_W-1:0]    ref_count,
  output logic [rakt_pkg::PORT_CNT_W-1:0]    entry_count,
  output logic [rakt_pkg::PORT_CNT_W-1:0]    evicted
);

  rakt_pkg::state_t                state;
  rakt_pkg::state_t                state_next;
  rakt_pkg::cmd_t                  cmd;
  logic [rakt_pkg::KEY_W-1:0]      key_q;
  logic                            chk;
  logic [rakt_pkg::LWM_W-1:0]      clean_floor;
  logic [rakt_pkg::CNT_W-1:0]      valid_total;
  logic [rakt_pkg::CNT_W-1:0]      acc;
  logic [rakt_pkg::CNT_W-1:0]      acc_next;
  logic [rakt_pkg::GRP_W-1:0]      grp;
  logic [rakt_pkg::EVEC_W-1:0]     evict_vec;
  logic [rakt_pkg::EVEC_W-1:0]     evict_vec_next;
  logic [rakt_pkg::GROUP-1:0]      grp_bits;
  logic [rakt_pkg::GCNT_W-1:0]     grp_pop;

  rakt_pkg::cell_ctl_t             ctl;
  rakt_pkg::chain_t                chain [rakt_pkg::CAPACITY+1];
  logic [rakt_pkg::CAPACITY-1:0]   valid_vec;
  logic [rakt_pkg::CAPACITY-1:0]   evict_bits;

  logic accept;
  logic skip;
  logic hit;
  logic room;
  logic last_grp;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign skip = chk && (32'(valid_total) <= 32'(clean_floor));
  assign hit  = chain[rakt_pkg::CAPACITY].hit_any;
  assign room = (32'(valid_total) < rakt_pkg::CAPACITY) &&
                chain[rakt_pkg::CAPACITY].free_seen;
  assign last_grp = (32'(grp) == rakt_pkg::NGROUPS - 1);

  always_comb begin
    ctl.exec_ref   = (state == rakt_pkg::S_EXEC) && (cmd == rakt_pkg::CMD_REF);
    ctl.exec_clean = (state == rakt_pkg::S_EXEC) && (cmd == rakt_pkg::CMD_CLEAN) && !skip;
    ctl.insert_ok  = !hit && room;
    ctl.key        = key_q;
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < rakt_pkg::CAPACITY; i++) begin : g_cell
    rakt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .valid     (valid_vec[i]),
      .evict     (evict_bits[i])
    );
  end

  always_comb begin
    evict_vec_next = '0;
    evict_vec_next[rakt_pkg::CAPACITY-1:0] = evict_bits;
  end

  always_comb begin
    grp_bits = evict_vec[grp*rakt_pkg::GROUP +: rakt_pkg::GROUP];
    grp_pop  = '0;
    for (int b = 0; b < rakt_pkg::GROUP; b++) begin
      grp_pop = grp_pop + rakt_pkg::GCNT_W'(grp_bits[b]);
    end
    acc_next = acc + rakt_pkg::CNT_W'(grp_pop);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rakt_pkg::S_IDLE: begin
        if (accept) state_next = rakt_pkg::S_EXEC;
      end
      rakt_pkg::S_EXEC: begin
        if (cmd == rakt_pkg::CMD_CLEAN && !skip) state_next = rakt_pkg::S_COUNT;
        else state_next = rakt_pkg::S_IDLE;
      end
      rakt_pkg::S_COUNT: begin
        if (last_grp) state_next = rakt_pkg::S_IDLE;
      end
      default: state_next = rakt_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state != rakt_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rakt_pkg::S_IDLE;
      clean_floor <= rakt_pkg::LWM_RESET;
      valid_total <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_valid && cfg_ready) clean_floor <= cfg_data;
      if (state == rakt_pkg::S_EXEC && cmd == rakt_pkg::CMD_REF) begin
        done <= 1'b1;
        if (!hit && room) valid_total <= valid_total + 1'b1;
      end else if (state == rakt_pkg::S_EXEC && skip) begin
        done <= 1'b1;
      end else if (state == rakt_pkg::S_COUNT && last_grp) begin
        done        <= 1'b1;
        valid_total <= (valid_total >= acc_next) ? valid_total - acc_next : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd   <= rakt_pkg::cmd_t'(command);
      key_q <= key;
      chk   <= gate_clean;
    end
    if (state == rakt_pkg::S_EXEC) begin
      evict_vec <= evict_vec_next;
      acc       <= '0;
      grp       <= '0;
    end else if (state == rakt_pkg::S_COUNT) begin
      acc <= acc_next;
      grp <= grp + 1'b1;
    end
    if (state == rakt_pkg::S_EXEC && cmd == rakt_pkg::CMD_REF) begin
      evicted <= '0;
      if (hit) begin
        status      <= rakt_pkg::ST_HIT;
        ref_count   <= rakt_pkg::PORT_REF_W'(chain[rakt_pkg::CAPACITY].hit_refs);
        entry_count <= rakt_pkg::PORT_CNT_W'(valid_total);
      end else if (room) begin
        status      <= rakt_pkg::ST_INSERTED;
        ref_count   <= rakt_pkg::PORT_REF_W'(1);
        entry_count <= rakt_pkg::PORT_CNT_W'(valid_total + 1'b1);
      end else begin
        status      <= rakt_pkg::ST_REFUSED;
        ref_count   <= '0;
        entry_count <= rakt_pkg::PORT_CNT_W'(valid_total);
      end
    end else if (state == rakt_pkg::S_EXEC && skip) begin
      status      <= rakt_pkg::ST_SKIPPED;
      ref_count   <= '0;
      entry_count <= rakt_pkg::PORT_CNT_W'(valid_total);
      evicted     <= '0;
    end else if (state == rakt_pkg::S_COUNT && last_grp) begin
      status      <= rakt_pkg::ST_CLEANED;
      ref_count   <= '0;
      entry_count <= rakt_pkg::PORT_CNT_W'((valid_total >= acc_next) ?
                                            valid_total - acc_next : '0);
      evicted     <= rakt_pkg::PORT_CNT_W'(acc_next);
    end
  end

  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> state == rakt_pkg::S_IDLE)
    else $error("result strobe outside idle");

  a_total_bound : assert property (@(posedge clk) disable iff (rst)
    32'(valid_total) <= rakt_pkg::CAPACITY)
    else $error("entry count above capacity");

  a_total_match : assert property (@(posedge clk) disable iff (rst)
    state == rakt_pkg::S_IDLE |-> $countones(valid_vec) == 32'(valid_total))
    else $error("entry count disagrees with valid bits");

  a_accept_exec : assert property (@(posedge clk) disable iff (rst)
    accept |=> state == rakt_pkg::S_EXEC)
    else $error("accepted beat not executed");

  a_insert_one : assert property (@(posedge clk) disable iff (rst)
    done && status == rakt_pkg::ST_INSERTED |-> ref_count == rakt_pkg::PORT_REF_W'(1))
    else $error("insert reported count other than one");

endmodule
